FILE: sv/pidf_pkg.sv
// Shared types and constants of the pair index de-duplication filter.
package pidf_pkg;

    localparam int MAX_ROWS_DEF = 64;

    localparam int IDX_W     = 7;
    localparam int IDXF_W    = 2 * IDX_W;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register select is address bit 2 (word-aligned decode)
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_SYM_MODE  = 1'b1;

    localparam logic [IDX_W-1:0] ROW_COUNT_RST = 7'd64;
    localparam logic             SYM_MODE_RST  = 1'b0;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } pidf_state_t;

endpackage

FILE: sv/pair_index_dedup_filter_core.sv
// Top level of the pair index de-duplication filter: seen-bitmap set membership.
//
// Usage:
//   Input stream s_*: one (row, column) pair per transaction, 1-based indices.
//   Result stream m_*: the pair after the optional symmetric swap, with flags
//   is_new (pair recorded for the first time) and out_of_range (a coordinate
//   outside 1..row count; bitmap left alone). One result per input transaction.
//   APB port: row count at 0x0, symmetric_mode at 0x4; write only while idle.
// Pipeline: an accepted input is registered into the check stage (bitmap read),
//   then check-and-mark moves it into the output register that drives m_tvalid.
// Throughput: one pair per cycle unless m_tready stalls. Each pair makes one
//   read-modify-write of the bitmap RAM; a pair that follows a write to the
//   same bit picks the new value up by forwarding.
// Reset: the bitmap RAM is cleared one bit a cycle, all MAX_ROWS*MAX_ROWS bits
//   (4096 at the default), while s_tready stays low; registers are writable.
// Stall: when m_tready is low the result is held in the output register; one
//   more pair is absorbed in the check stage, then s_tready drops.
module pair_index_dedup_filter_core #(
    parameter int MAX_ROWS = pidf_pkg::MAX_ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: row_index[6:0], col_index[13:7], zero pad[15:14]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pidf_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: row_out[6:0], col_out[13:7], zero pad[15:14]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pidf_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: is_new[0], out_of_range[1]
    output logic [pidf_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pidf_pkg::APB_AW-1:0]    paddr,
    input  logic [pidf_pkg::APB_DW-1:0]    pwdata,
    output logic [pidf_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    import pidf_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    // configuration registers
    logic [IDX_W-1:0] row_count_reg;
    logic             sym_mode_reg;
    logic             cfg_wr;

    // clearing sequencer
    pidf_state_t      state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg;
    logic             clr_we;

    // input decode
    logic [IDX_W-1:0] in_row, in_col, sw_row, sw_col, rows_eff;
    logic             in_oor, accept;
    logic [IDXF_W-1:0] idx_full;
    logic [AW-1:0]    in_idx;

    // check stage
    logic             p1_valid_reg;
    logic [IDX_W-1:0] p1_row_reg, p1_col_reg;
    logic             p1_oor_reg, p1_fwd_reg;
    logic [AW-1:0]    p1_idx_reg;
    logic             p1_is_new, p1_we, p1_move, out_free;

    // output register
    logic             m_valid_reg;
    logic [IDX_W-1:0] m_row_reg, m_col_reg;
    logic             m_new_reg, m_oor_reg;

    // bitmap RAM
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic             ram_wdata, ram_rdata;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= ROW_COUNT_RST;
            sym_mode_reg  <= SYM_MODE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ROW_COUNT: row_count_reg <= pwdata[IDX_W-1:0];
                REG_SYM_MODE:  sym_mode_reg  <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_ROW_COUNT: prdata = APB_DW'(row_count_reg);
            REG_SYM_MODE:  prdata = APB_DW'(sym_mode_reg);
        endcase
    end

    // ---------------- clearing sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (clr_we) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        clr_we     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_we = 1'b1;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                state_next = ST_RUN;
            end
        endcase
    end

    // ---------------- input decode ----------------
    assign in_row = s_tdata[IDX_W-1:0];
    assign in_col = s_tdata[2*IDX_W-1:IDX_W];

    // saturate the row count at the bitmap size
    assign rows_eff = (32'(row_count_reg) > MAX_ROWS) ? IDX_W'(MAX_ROWS) : row_count_reg;

    always_comb begin
        sw_row = in_row;
        sw_col = in_col;
        if (sym_mode_reg && (in_col > in_row)) begin
            sw_row = in_col;
            sw_col = in_row;
        end
    end

    assign in_oor = (sw_row == '0) || (sw_row > rows_eff) ||
                    (sw_col == '0) || (sw_col > rows_eff);

    // in range the index stays below rows^2, so the cast loses nothing
    assign idx_full = IDXF_W'(sw_row - 1'b1) +
                      IDXF_W'(sw_col - 1'b1) * IDXF_W'(rows_eff);
    assign in_idx   = AW'(idx_full);

    assign out_free = !m_valid_reg || m_tready;
    assign p1_move  = p1_valid_reg && out_free;
    assign s_tready = (state_reg == ST_RUN) && (!p1_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;

    // ---------------- check stage ----------------
    assign p1_is_new = !p1_oor_reg && !(ram_rdata || p1_fwd_reg);
    assign p1_we     = p1_move && p1_is_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_move) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_row_reg <= sw_row;
            p1_col_reg <= sw_col;
            p1_oor_reg <= in_oor;
            p1_idx_reg <= in_idx;
            // the read misses a write to the same bit in this cycle: forward it
            p1_fwd_reg <= p1_we && (p1_idx_reg == in_idx);
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            m_row_reg <= p1_row_reg;
            m_col_reg <= p1_col_reg;
            m_new_reg <= p1_is_new;
            m_oor_reg <= p1_oor_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_col_reg, m_row_reg});
    assign m_tuser  = {m_oor_reg, m_new_reg};

    // ---------------- bitmap RAM ----------------
    assign ram_we    = clr_we || p1_we;
    assign ram_waddr = clr_we ? clr_cnt_reg : p1_idx_reg;
    assign ram_wdata = !clr_we;

    pidf_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    // ---------------- assertions ----------------
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during bitmap clear");

    a_mark_only_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && (state_reg == ST_RUN)) |-> (p1_move && !p1_oor_reg))
        else $error("bitmap written by an out-of-range or idle pair");

    a_fwd_not_new: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_fwd_reg) |-> !p1_is_new)
        else $error("forwarded repeat reported as new");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_new_reg && m_oor_reg))
        else $error("out-of-range pair reported as new");

    a_clear_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_CLEAR) && (clr_cnt_reg == CLR_LAST)) |=> (state_reg == ST_RUN))
        else $error("clear pass did not finish");

endmodule

FILE: sv/pidf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pidf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = pidf_pkg::MAX_ROWS_DEF * pidf_pkg::MAX_ROWS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // old data is returned on a same-address read and write
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/pidf_pair_checker.sv
// Checker for the pair index de-duplication filter: predicts each result and compares it.
`timescale 1ns / 1ps

module pidf_pair_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [pidf_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pidf_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [pidf_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [pidf_pkg::APB_AW-1:0]    paddr,
    input  logic [pidf_pkg::APB_DW-1:0]    pwdata,
    output int                             outstanding,
    output int                             mismatches,
    output int                             n_new,
    output int                             n_repeat,
    output int                             n_oor,
    output int                             n_swapped,
    output int                             n_reg_writes
);
    import pidf_pkg::*;

    localparam int ROWS_CAP = MAX_ROWS_DEF;
    localparam int MAP_DEPTH = ROWS_CAP * ROWS_CAP;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             is_new;
        logic             oor;
    } pair_verdict_t;

    logic             seen_bits [MAP_DEPTH];
    logic [IDX_W-1:0] rows_reg;
    logic             sym_reg;
    pair_verdict_t    awaited_verdicts [$];

    // Fold, range-check and mark one pair against the local bitmap copy.
    function automatic pair_verdict_t fold_and_mark(input logic [IDX_W-1:0] row_in,
                                                    input logic [IDX_W-1:0] col_in);
        pair_verdict_t v;
        int unsigned   r;
        int unsigned   c;
        int unsigned   rows;
        int unsigned   idx;
        r = row_in;
        c = col_in;
        rows = (rows_reg > ROWS_CAP) ? ROWS_CAP : rows_reg;
        if (sym_reg && c > r) begin
            r = col_in;
            c = row_in;
        end
        v.row = r[IDX_W-1:0];
        v.col = c[IDX_W-1:0];
        v.is_new = 1'b0;
        v.oor = (r < 1 || r > rows || c < 1 || c > rows);
        if (!v.oor) begin
            idx = (r - 1) + (c - 1) * rows;
            if (idx < MAP_DEPTH && !seen_bits[idx]) begin
                seen_bits[idx] = 1'b1;
                v.is_new = 1'b1;
            end
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        pair_verdict_t want;
        pair_verdict_t got;
        if (!aresetn) begin
            foreach (seen_bits[i]) seen_bits[i] = 1'b0;
            rows_reg = ROW_COUNT_RST;
            sym_reg = SYM_MODE_RST;
            awaited_verdicts.delete();
            mismatches = 0;
            n_new = 0;
            n_repeat = 0;
            n_oor = 0;
            n_swapped = 0;
            n_reg_writes = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                n_reg_writes++;
                if (paddr[2] == REG_ROW_COUNT)
                    rows_reg = pwdata[IDX_W-1:0];
                else
                    sym_reg = pwdata[0];
            end
            // Compare before pushing, so a result can never match its own input
            if (m_tvalid && m_tready) begin
                got.row = m_tdata[IDX_W-1:0];
                got.col = m_tdata[2*IDX_W-1:IDX_W];
                got.is_new = m_tuser[0];
                got.oor = m_tuser[1];
                if (awaited_verdicts.size() == 0) begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected result row=%0d col=%0d new=%0b oor=%0b",
                                 $realtime, got.row, got.col, got.is_new, got.oor);
                    mismatches++;
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (want !== got) begin
                        if (mismatches < 10)
                            $display("[%0t] expected %0d,%0d,%0b,%0b got %0d,%0d,%0b,%0b",
                                     $realtime, want.row, want.col, want.is_new, want.oor,
                                     got.row, got.col, got.is_new, got.oor);
                        mismatches++;
                    end
                    if (want.oor) n_oor++;
                    else if (want.is_new) n_new++;
                    else n_repeat++;
                end
            end
            if (s_tvalid && s_tready) begin
                want = fold_and_mark(s_tdata[IDX_W-1:0], s_tdata[2*IDX_W-1:IDX_W]);
                if (want.row != s_tdata[IDX_W-1:0]) n_swapped++;
                awaited_verdicts.insert(awaited_verdicts.size(), want);
            end
        end
        outstanding = awaited_verdicts.size();
    end

endmodule

FILE: tb/pair_index_dedup_filter_core_test.sv
// Stimulus and verdict for the pair index de-duplication filter regression.
`timescale 1ns / 1ps

module pair_index_dedup_filter_core_test;
    import pidf_pkg::*;

    localparam int LONG_HOLD = 300;
    localparam int DRAIN_LIMIT = 20000;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SLOW
    } rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int outstanding;
    int mismatches;
    int n_new;
    int n_repeat;
    int n_oor;
    int n_swapped;
    int n_reg_writes;

    int burst_left;
    bit steady_feed;
    int long_stall_asks;
    int long_stall_done;
    int rows_now;

    pair_index_dedup_filter_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pidf_pair_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .outstanding  (outstanding),
        .mismatches   (mismatches),
        .n_new        (n_new),
        .n_repeat     (n_repeat),
        .n_oor        (n_oor),
        .n_swapped    (n_swapped),
        .n_reg_writes (n_reg_writes)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("pair_index_dedup_filter_core regression: fail");
        $finish;
    end

    // Result side: random stall modes, plus a long hold-off on request
    initial begin
        rx_mode_t rx_mode;
        int mode_left;
        int hold_left;
        rx_mode = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && long_stall_asks > long_stall_done) begin
                long_stall_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE: m_tready = 1'b1;
                    RX_COIN: m_tready = 1'($urandom_range(0, 1));
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic sel, input logic [IDX_W-1:0] value);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {sel, 2'b00};
        // upper bits are don't-care to the block; scramble them
        pwdata = ($urandom() & ~32'h7F) | APB_DW'(value);
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (sel == REG_ROW_COUNT) rows_now = (value > MAX_ROWS_DEF) ? MAX_ROWS_DEF : value;
    endtask

    task automatic send_pair(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
        @(negedge aclk);
        if (!steady_feed && burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        s_tdata = {2'b00, col, row};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and hold until every result is back, then let the pipeline settle
    task automatic drain_results;
        int guard;
        guard = 0;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (outstanding != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (outstanding != 0) begin
            $display("pair_index_dedup_filter_core regression: fail");
            $finish;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_random_pair;
        int pick;
        int edge_sel;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 78 && rows_now > 0) begin
            r = IDX_W'($urandom_range(1, rows_now));
            c = IDX_W'($urandom_range(1, rows_now));
        end else if (pick < 90) begin
            r = IDX_W'($urandom_range(0, 127));
            c = IDX_W'($urandom_range(0, 127));
        end else begin
            edge_sel = $urandom_range(0, 4);
            case (edge_sel)
                0: r = 0;
                1: r = 1;
                2: r = IDX_W'(rows_now);
                3: r = IDX_W'(rows_now + 1);
                default: r = 127;
            endcase
            c = IDX_W'($urandom_range(0, rows_now + 1));
        end
        send_pair(r, c);
    endtask

    initial begin
        int unsigned phase_rows [10] = '{5, 1, 64, 127, 0, 12, 33, 64, 3, 100};
        int phase;
        int k;
        int guard;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        steady_feed = 1'b0;
        long_stall_asks = 0;
        long_stall_done = 0;
        rows_now = MAX_ROWS_DEF;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset settings, corners and out-of-range coordinates
        send_pair(1, 1);
        send_pair(64, 64);
        send_pair(1, 64);
        send_pair(64, 1);
        send_pair(1, 1);
        send_pair(0, 5);
        send_pair(5, 0);
        send_pair(65, 3);
        send_pair(127, 127);
        send_pair(0, 0);
        drain_results();
        // rows above the cap saturate
        write_reg(REG_ROW_COUNT, 7'd127);
        send_pair(64, 64);
        send_pair(65, 1);
        send_pair(2, 64);
        drain_results();
        write_reg(REG_SYM_MODE, 7'd1);
        send_pair(3, 10);
        send_pair(10, 3);
        send_pair(0, 5);
        send_pair(127, 0);
        drain_results();
        write_reg(REG_ROW_COUNT, 7'd0);
        send_pair(1, 1);
        send_pair(0, 0);
        drain_results();
        write_reg(REG_ROW_COUNT, 7'd1);
        send_pair(1, 1);
        send_pair(1, 1);
        send_pair(1, 2);
        drain_results();

        // Random phases over a spread of settings; the bitmap carries across them
        for (phase = 0; phase < 10; phase++) begin
            write_reg(REG_ROW_COUNT, IDX_W'(phase_rows[phase]));
            write_reg(REG_SYM_MODE, IDX_W'($urandom_range(0, 1)));
            steady_feed = (phase % 3 == 1);
            for (k = 0; k < 50; k++) begin
                if (phase == 2 && k == 8) long_stall_asks++;
                if (phase == 6 && k == 20) long_stall_asks++;
                if (phase == 5 && k == 25) drain_results();
                send_random_pair();
            end
            drain_results();
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        guard = 0;
        while (outstanding != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        $display("covered %0d results: %0d new, %0d repeats, %0d out of range, %0d swapped",
                 n_new + n_repeat + n_oor, n_new, n_repeat, n_oor, n_swapped);
        $display("register writes %0d, row counts 0 to 127, both fold modes", n_reg_writes);
        if (mismatches == 0 && outstanding == 0) begin
            $display("pair_index_dedup_filter_core regression: pass");
        end else begin
            $display("pair_index_dedup_filter_core regression: fail");
        end
        $finish;
    end

endmodule
